// ----- rtl/pcim_pkg.sv -----
`default_nettype none
package pcim_pkg;

   localparam int INDEX_W         = 6;
   localparam int ID_W            = 32;
   localparam int CLASS_W         = 24;
   localparam int DATA_W          = 32;
   localparam int DEF_TABLE_DEPTH = 64;

   localparam int REQ_DATA_W = 216;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   localparam logic [ID_W-1:0] ANY_ID = '1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    vendor;
      logic [ID_W-1:0]    device;
      logic [ID_W-1:0]    subsys_vendor;
      logic [ID_W-1:0]    subsys_device;
      logic [CLASS_W-1:0] cls;
      logic [CLASS_W-1:0] cls_mask;
      logic [DATA_W-1:0]  data;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PUSH
   } state_type;

   function automatic logic id_agrees(logic [ID_W-1:0] want, logic [ID_W-1:0] have);
      return (want == ANY_ID) || (want == have);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pcim_table.sv -----
`default_nettype none
module pcim_table #(
   parameter int DEPTH = pcim_pkg::DEF_TABLE_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire pcim_pkg::entry_type wr_entry,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output      pcim_pkg::entry_type rd_entry
);
   import pcim_pkg::*;

   entry_type        mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   entry_type        rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // unwritten slots read as terminators
   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ----- rtl/pci_id_table_match_unit.sv -----
`default_nettype none
// channel  direction  tdata (low bit up)                                   tuser
// req      in         entry index, vendor, device, subsystem vendor,       operation
//                     subsystem device, class, class mask, entry data
// rsp      out        match_index, match_data                              matched
//
// A load raises rsp_tvalid through ST_PUSH and the rsp register, once that register is free.
// A query walks the table one entry a cycle through the table memory's read port:
// it stops at a terminator, a hit or the last slot, then reports through ST_PUSH and the rsp register.
// Slots at 64 and above can never be loaded and so are not stored.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// A new word is taken while a result waits in the rsp register; the next result holds behind it.
module pci_id_table_match_unit #(
   parameter int TABLE_DEPTH = pcim_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // entry index, vendor, device, subsystem vendor, subsystem device,
   // class, class mask, entry data, zero pad
   input  wire logic [pcim_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  wire logic [pcim_pkg::REQ_USER_W-1:0]     req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // match_index, match_data, zero pad
   output      logic [pcim_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // matched
   output      logic [pcim_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import pcim_pkg::*;

   localparam int STORE_DEPTH = (TABLE_DEPTH < (1 << INDEX_W)) ? TABLE_DEPTH : (1 << INDEX_W);
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(STORE_DEPTH - 1);
   localparam logic [INDEX_W:0]   STORE_SIZE = (INDEX_W + 1)'(STORE_DEPTH);

   logic [INDEX_W-1:0] req_index;
   entry_type          req_entry;
   logic               req_op;
   logic               accept;

   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_entry = {req_tdata[INDEX_W +: ID_W],
                       req_tdata[INDEX_W + ID_W +: ID_W],
                       req_tdata[INDEX_W + 2*ID_W +: ID_W],
                       req_tdata[INDEX_W + 3*ID_W +: ID_W],
                       req_tdata[INDEX_W + 4*ID_W +: CLASS_W],
                       req_tdata[INDEX_W + 4*ID_W + CLASS_W +: CLASS_W],
                       req_tdata[INDEX_W + 4*ID_W + 2*CLASS_W +: DATA_W]};
   assign req_op    = req_tuser[0];
   assign accept    = req_tvalid && req_tready;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  addr_ff, addr_in;
   logic               last_ff, last_in;
   logic               chk_ff, chk_in;
   logic [SLOT_W-1:0]  chk_idx_ff, chk_idx_in;
   entry_type          key_ff, key_in;
   logic               res_hit_ff, res_hit_in;
   logic [INDEX_W-1:0] res_idx_ff, res_idx_in;
   logic [DATA_W-1:0]  res_data_ff, res_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic              issue;
   entry_type         rd_entry;
   logic              is_end;
   logic              is_hit;

   pcim_table #(
      .DEPTH (STORE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (req_index[SLOT_W-1:0]),
      .wr_entry (req_entry),
      .rd_addr  (addr_ff),
      .rd_entry (rd_entry)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign wr_en      = accept && (req_op == OP_LOAD) && ({1'b0, req_index} < STORE_SIZE);
   assign issue      = (state_ff == ST_WALK) && !last_ff;

   assign is_end = (rd_entry == '0);
   assign is_hit = id_agrees(rd_entry.vendor, key_ff.vendor)
                && id_agrees(rd_entry.device, key_ff.device)
                && id_agrees(rd_entry.subsys_vendor, key_ff.subsys_vendor)
                && id_agrees(rd_entry.subsys_device, key_ff.subsys_device)
                && (((key_ff.cls ^ rd_entry.cls) & rd_entry.cls_mask) == '0);

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      last_in     = last_ff;
      chk_in      = issue;
      chk_idx_in  = addr_ff;
      key_in      = key_ff;
      res_hit_in  = res_hit_ff;
      res_idx_in  = res_idx_ff;
      res_data_in = res_data_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (issue) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == LAST_SLOT) begin
            last_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            addr_in     = '0;
            last_in     = 1'b0;
            res_hit_in  = 1'b0;
            res_idx_in  = '0;
            res_data_in = '0;
            if (accept) begin
               key_in = req_entry;
               if (req_op == OP_QUERY) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_WALK: begin
            if (chk_ff) begin
               if (is_end) begin
                  state_in = ST_PUSH;
               end else if (is_hit) begin
                  res_hit_in  = 1'b1;
                  res_idx_in  = INDEX_W'(chk_idx_ff);
                  res_data_in = rd_entry.data;
                  state_in    = ST_PUSH;
               end else if (chk_idx_ff == LAST_SLOT) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_data_in  = res_data_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      chk_idx_ff  <= chk_idx_in;
      key_ff      <= key_in;
      res_hit_ff  <= res_hit_in;
      res_idx_ff  <= res_idx_in;
      res_data_ff <= res_data_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - INDEX_W - DATA_W){1'b0}}, rsp_data_ff, rsp_idx_ff};

endmodule
`default_nettype wire
